[rtl/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, constants and the shift-add-3 step for the card number check.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int CARD_W        = 54;
  localparam int BCD_DIGITS    = 17;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int BITS_PER_STEP = 3;
  localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
  localparam int CNT_W         = 5;
  localparam int MAX_DIGITS    = 16;

  localparam logic [CNT_W-1:0] LEN_VISA_SHORT = CNT_W'(13);
  localparam logic [CNT_W-1:0] LEN_AMEX       = CNT_W'(15);
  localparam logic [CNT_W-1:0] LEN_LONG       = CNT_W'(16);

  localparam logic [1:0] BRAND_INVALID    = 2'd0;
  localparam logic [1:0] BRAND_VISA       = 2'd1;
  localparam logic [1:0] BRAND_AMEX       = 2'd2;
  localparam logic [1:0] BRAND_MASTERCARD = 2'd3;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef struct packed {
    logic             sum_zero;
    logic [CNT_W-1:0] count;
  } lbc_scan_res_t;

  // One double-dabble step: adjust every digit of five or more by three,
  // then shift the next binary bit in at the bottom.
  function automatic bcd_t dd_step(input bcd_t bcd, input logic b);
    bcd_t adj;
    adj = bcd;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

[rtl/card_number_luhn_brand_check_top.sv]
// ----------------------------------------------------------------------------
// card_number_luhn_brand_check_top
// Luhn mod-10 check, digit count and brand sort for one binary card number.
// ----------------------------------------------------------------------------
// The input channel takes one card number per beat (in_valid, in_stall,
// in_card_number). The result channel gives one beat per card number with
// the brand, the Luhn flag and the decimal digit count.
// A card number is first turned into 17 BCD digits by a shift-add-3 unit,
// three bits per clock. A scan unit then walks the digits from the right,
// one per clock, keeping the Luhn sum modulo ten and the position of the
// highest nonzero digit. The brand is decided from the digit count and the
// top BCD digits as the output register loads. A new item is taken only
// once the previous one has reached the output register.
// in_stall is high from acceptance until the result has loaded into the
// output register, also while a finished result waits for it.
// When the receiver stalls, the finished result waits in the output register;
// a second result that finishes meanwhile holds the block until it can load.
// Reset empties the block and the output register; the first item can be
// taken as soon as reset is released.
// ----------------------------------------------------------------------------
module card_number_luhn_brand_check_top
  import lbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CARD_W-1:0] in_card_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_brand,
  output logic              out_luhn_ok,
  output logic [CNT_W-1:0]  out_digit_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       brand_r, brand_nxt;
  logic             ok_r, ok_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic          in_acc;
  logic          conv_done;
  bcd_t          conv_bcd;
  logic          scan_done;
  lbc_scan_res_t scan_res;
  logic          res_ok;
  logic [1:0]    res_brand;
  logic          out_free;
  logic          res_ready;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  lbc_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .bin   (in_card_number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  lbc_digit_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .bcd   (conv_bcd),
    .done  (scan_done),
    .res   (scan_res)
  );

  // The BCD word stays put in the converter until the next item starts.
  always_comb begin
    res_ok = scan_res.sum_zero && (scan_res.count != '0) &&
             (scan_res.count <= CNT_W'(MAX_DIGITS));
    res_brand = BRAND_INVALID;
    if (res_ok) begin
      if (scan_res.count == LEN_VISA_SHORT) begin
        if (conv_bcd[4*12 +: 4] == 4'd4) begin
          res_brand = BRAND_VISA;
        end
      end else if (scan_res.count == LEN_AMEX) begin
        if (conv_bcd[4*14 +: 4] == 4'd3 &&
            (conv_bcd[4*13 +: 4] == 4'd4 || conv_bcd[4*13 +: 4] == 4'd7)) begin
          res_brand = BRAND_AMEX;
        end
      end else if (scan_res.count == LEN_LONG) begin
        if (conv_bcd[4*15 +: 4] == 4'd5 && (conv_bcd[4*14 +: 4] inside {[4'd1:4'd5]})) begin
          res_brand = BRAND_MASTERCARD;
        end else if (conv_bcd[4*15 +: 4] == 4'd4) begin
          res_brand = BRAND_VISA;
        end
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign res_ready = (state_r == ST_SCAN && scan_done) || (state_r == ST_HOLD);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    brand_nxt     = brand_r;
    ok_nxt        = ok_r;
    count_nxt     = count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN, ST_HOLD: begin
        if (res_ready) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            brand_nxt     = res_brand;
            ok_nxt        = res_ok;
            count_nxt     = scan_res.count;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    brand_r <= brand_nxt;
    ok_r    <= ok_nxt;
    count_r <= count_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_brand       = brand_r;
  assign out_luhn_ok     = ok_r;
  assign out_digit_count = count_r;

  a_conv_done_in_conv : assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == ST_CONV)
    else $error("converter finished outside the conversion phase");

  a_scan_done_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == ST_SCAN)
    else $error("digit scan finished outside the scan phase");

  a_brand_needs_luhn : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brand != BRAND_INVALID) |-> out_luhn_ok)
    else $error("brand reported without a passing checksum");

  a_ok_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_luhn_ok) |->
      (out_digit_count != '0 && out_digit_count <= CNT_W'(MAX_DIGITS)))
    else $error("checksum passed with a digit count out of range");

  a_accept_then_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block did not go busy after taking an item");

endmodule

[rtl/lbc_bin2bcd.sv]
// ----------------------------------------------------------------------------
// lbc_bin2bcd
// Iterative binary to BCD converter, three input bits per clock.
// ----------------------------------------------------------------------------
module lbc_bin2bcd
  import lbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CARD_W-1:0] bin,
  output logic              done,
  output bcd_t              bcd
);

  logic [CARD_W-1:0] bin_r, bin_nxt;
  bcd_t              bcd_r, bcd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  bcd_t              s1, s2, s3;

  assign s1 = dd_step(bcd_r, bin_r[CARD_W-1]);
  assign s2 = dd_step(s1, bin_r[CARD_W-2]);
  assign s3 = dd_step(s2, bin_r[CARD_W-3]);

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = {bin_r[CARD_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
      bcd_nxt = s3;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

[rtl/lbc_digit_scan.sv]
// ----------------------------------------------------------------------------
// lbc_digit_scan
// Walks the BCD digits from the right, one a clock, for the Luhn sum and count.
// ----------------------------------------------------------------------------
module lbc_digit_scan
  import lbc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bcd_t          bcd,
  output logic          done,
  output lbc_scan_res_t res
);

  bcd_t             work_r, work_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       sum_r, sum_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       dig;
  logic [4:0]       dbl;
  logic [4:0]       term;
  logic [4:0]       acc;

  assign dig = work_r[3:0];
  assign dbl = {dig, 1'b0};

  always_comb begin
    // Odd positions from the right are doubled and folded back to one digit.
    if (idx_r[0]) begin
      term = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
    end else begin
      term = {1'b0, dig};
    end
    acc = {1'b0, sum_r} + term;
    if (acc >= 5'd10) begin
      acc = acc - 5'd10;
    end
  end

  always_comb begin
    work_nxt  = work_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      work_nxt  = bcd;
      idx_nxt   = '0;
      count_nxt = '0;
      sum_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      work_nxt = {4'd0, work_r[BCD_W-1:4]};
      idx_nxt  = idx_r + 1'b1;
      sum_nxt  = acc[3:0];
      if (dig != 4'd0) begin
        count_nxt = idx_r + 1'b1;
      end
      if (idx_r == CNT_W'(BCD_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    idx_r   <= idx_nxt;
    count_r <= count_nxt;
    sum_r   <= sum_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done         = done_r;
  assign res.sum_zero = (sum_r == 4'd0);
  assign res.count    = count_r;

endmodule
